/* sv/rrif_pkg.sv */
// Package for the RR interval feature block: request and result types,
// controller command and status types, register indexes and shared helpers.
// Depends on nothing.
package rrif_pkg;

    localparam int INITIAL_INTERVAL_DEF = 256;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_AVERAGE_DECAY_SHIFT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RATIO_SHIFT         = 2'd1;

    localparam logic [3:0] DECAY_SHIFT_RESET = 4'd3;
    localparam logic [3:0] RATIO_SHIFT_RESET = 4'd8;

    // Shifted numerator magnitude is at most 2^30, so 31 quotient bits.
    localparam int NUM_MAG_W = 31;
    localparam int DIV_STEPS = NUM_MAG_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [15:0] SAT_POS = 16'h7FFF;
    localparam logic [15:0] SAT_NEG = 16'h8000;

    typedef struct packed {
        logic [14:0] this_beat_delay;
        logic [14:0] next_beat_delay;
    } rrif_in_t;

    typedef struct packed {
        logic signed [15:0] prev_interval;
        logic signed [15:0] next_interval;
        logic signed [15:0] prev2_interval;
        logic signed [15:0] average_interval;
        logic signed [15:0] prev_deviation;
        logic signed [15:0] next_deviation;
        logic signed [15:0] ratio_prev;
        logic signed [15:0] ratio_next;
        logic               ratio_saturated;
    } rrif_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DONE
    } rrif_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } rrif_cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } rrif_sts_t;

    // Unsigned magnitude of a 16-bit two's complement value; -32768 gives 32768.
    function automatic logic [15:0] mag16(input logic [15:0] v);
        return v[15] ? 16'(-v) : v;
    endfunction

    // Turns a quotient magnitude into the signed, saturated ratio.
    // Bit 16 of the result is the saturation flag.
    function automatic logic [16:0] ratio_result(input logic [NUM_MAG_W-1:0] q,
                                                 input logic neg,
                                                 input logic num_neg,
                                                 input logic den_zero);
        logic [16:0] r;
        r = '0;
        if (den_zero) begin
            r = {1'b1, (num_neg ? SAT_NEG : SAT_POS)};
        end else if (!neg) begin
            if (q > NUM_MAG_W'(32767)) begin
                r = {1'b1, SAT_POS};
            end else begin
                r = {1'b0, q[15:0]};
            end
        end else begin
            if (q > NUM_MAG_W'(32768)) begin
                r = {1'b1, SAT_NEG};
            end else begin
                r = {1'b0, 16'(-q[15:0])};
            end
        end
        return r;
    endfunction

endpackage

/* sv/rrif_ctrl.sv */
// Controller of the RR interval feature block: sequences load, division
// steps and result hand-off. Depends on rrif_pkg.
module rrif_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                beat_valid,
    output logic                beat_stall,
    input  rrif_pkg::rrif_sts_t sts,
    output rrif_pkg::rrif_cmd_t cmd
);
    import rrif_pkg::*;

    rrif_state_t state_reg;
    rrif_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (beat_valid)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        beat_stall = 1'b1;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                beat_stall = 1'b0;
                cmd.load   = beat_valid;
            end
            ST_DIVIDE:
            begin
                cmd.step = 1'b1;
            end
            ST_DONE:
            begin
                cmd.finish = sts.out_free;
            end
            default:
            begin
                beat_stall = 1'b1;
            end
        endcase
    end

endmodule

/* sv/rrif_datapath.sv */
// Datapath of the RR interval feature block: configuration and interval
// state, two radix-2 restoring divider lanes and the result register.
// Depends on rrif_pkg.
module rrif_datapath #(
    parameter int INITIAL_INTERVAL = rrif_pkg::INITIAL_INTERVAL_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rrif_pkg::rrif_cmd_t                  cmd,
    output rrif_pkg::rrif_sts_t                  sts,
    input  rrif_pkg::rrif_in_t                   beat,
    output logic                                 feat_valid,
    input  logic                                 feat_stall,
    output rrif_pkg::rrif_out_t                  feat,
    input  logic                                 cfg_we,
    input  logic [rrif_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rrif_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import rrif_pkg::*;

    localparam logic signed [15:0] INIT_IV = 16'(INITIAL_INTERVAL);
    localparam int LANES = 2;

    logic [3:0]         decay_shift_reg;
    logic [3:0]         ratio_shift_reg;
    logic signed [15:0] held_prev_reg;
    logic signed [15:0] held_prev2_reg;
    logic signed [15:0] held_avg_reg;
    logic signed [15:0] next_iv_reg;
    logic [CNT_W-1:0]   cnt_reg;
    rrif_out_t          out_reg;
    rrif_out_t          out_next;
    logic               out_valid_reg;

    // Lane 0 forms ratio_prev, lane 1 forms ratio_next.
    logic [NUM_MAG_W-1:0] quo_reg [LANES];
    logic [15:0]          rem_reg [LANES];
    logic [15:0]          den_reg [LANES];
    logic                 neg_reg [LANES];
    logic                 num_neg_reg [LANES];
    logic                 den_zero_reg [LANES];

    logic [15:0]          lane_num [LANES];
    logic [15:0]          lane_den [LANES];
    logic [NUM_MAG_W-1:0] quo_next [LANES];
    logic [15:0]          rem_next [LANES];
    logic [16:0]          lane_res [LANES];

    logic signed [15:0] beat_iv;
    logic signed [15:0] avg_next;

    assign beat_iv = 16'({1'b0, beat.this_beat_delay} - {1'b0, beat.next_beat_delay});

    assign lane_num[0] = held_prev_reg;
    assign lane_den[0] = held_prev2_reg;
    assign lane_num[1] = beat_iv;
    assign lane_den[1] = held_prev_reg;

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        logic [16:0] rem_sh;
        logic        ge;

        assign rem_sh      = {rem_reg[g], quo_reg[g][NUM_MAG_W-1]};
        assign ge          = rem_sh >= {1'b0, den_reg[g]};
        assign rem_next[g] = ge ? 16'(rem_sh - {1'b0, den_reg[g]}) : rem_sh[15:0];
        assign quo_next[g] = {quo_reg[g][NUM_MAG_W-2:0], ge};
        assign lane_res[g] = ratio_result(quo_reg[g], neg_reg[g], num_neg_reg[g],
                                          den_zero_reg[g]);
    end

    assign sts.div_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));
    assign sts.out_free = !out_valid_reg || !feat_stall;

    // Single-pole update with arithmetic shifts, wrapped to 16 bits.
    assign avg_next = held_avg_reg - (held_avg_reg >>> decay_shift_reg)
                      + (next_iv_reg >>> decay_shift_reg);

    always_comb
    begin
        out_next                  = out_reg;
        out_next.prev_interval    = held_prev_reg;
        out_next.next_interval    = next_iv_reg;
        out_next.prev2_interval   = held_prev2_reg;
        out_next.average_interval = held_avg_reg;
        out_next.prev_deviation   = held_prev_reg - held_avg_reg;
        out_next.next_deviation   = next_iv_reg - held_avg_reg;
        out_next.ratio_prev       = lane_res[0][15:0];
        out_next.ratio_next       = lane_res[1][15:0];
        out_next.ratio_saturated  = lane_res[0][16] | lane_res[1][16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_shift_reg <= DECAY_SHIFT_RESET;
            ratio_shift_reg <= RATIO_SHIFT_RESET;
            held_prev_reg   <= INIT_IV;
            held_prev2_reg  <= INIT_IV;
            held_avg_reg    <= INIT_IV;
            out_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_AVERAGE_DECAY_SHIFT: decay_shift_reg <= cfg_data;
                    REG_RATIO_SHIFT:         ratio_shift_reg <= cfg_data;
                    default:                 ;
                endcase
            end

            if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.step)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end

            if (cmd.finish)
            begin
                out_valid_reg  <= 1'b1;
                held_prev2_reg <= held_prev_reg;
                held_prev_reg  <= next_iv_reg;
                held_avg_reg   <= avg_next;
            end
            else if (!feat_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            next_iv_reg <= beat_iv;
        end
        if (cmd.finish)
        begin
            out_reg <= out_next;
        end
        for (int i = 0; i < LANES; i++)
        begin
            if (cmd.load)
            begin
                quo_reg[i]      <= NUM_MAG_W'(mag16(lane_num[i])) << ratio_shift_reg;
                rem_reg[i]      <= '0;
                den_reg[i]      <= mag16(lane_den[i]);
                neg_reg[i]      <= lane_num[i][15] ^ lane_den[i][15];
                num_neg_reg[i]  <= lane_num[i][15];
                den_zero_reg[i] <= (lane_den[i] == 16'd0);
            end
            else if (cmd.step)
            begin
                quo_reg[i] <= quo_next[i];
                rem_reg[i] <= rem_next[i];
            end
        end
    end

    assign feat       = out_reg;
    assign feat_valid = out_valid_reg;

endmodule

/* sv/rr_interval_features.sv */
// Top level of the RR interval feature block: joins the controller and the
// datapath. Depends on rrif_pkg, rrif_ctrl and rrif_datapath.
//
// Usage. Each request on the beat channel carries the sample delays of the
// current and the following heartbeat. A request is taken at a rising edge
// where beat_valid is high and beat_stall is low. For every request the block
// returns one result on the feat channel: the three most recent intervals,
// the running average, the two deviations from it and two fixed-point
// interval ratios with a saturation flag. A result is taken at an edge where
// feat_valid is high and feat_stall is low.
// Sequence: a request is accepted at one edge, then the two ratios are formed
// by two radix-2 restoring dividers running side by side, one quotient bit per
// cycle, and then the result moves into the output register once that register
// is free. A new request is taken only after that move, and the division sets
// the time that one request takes when the receiver keeps up.
// A waiting result does not block the next request: the block accepts and
// divides it, then holds the finished quotients until the output register
// frees. Reset clears the interval history and the average to the initial
// interval, loads the register reset values and empties the output register.
// Configuration writes take effect at once; the user must make them only while
// the block idles, and the block itself does not enforce this.
module rr_interval_features #(
    parameter int INITIAL_INTERVAL = rrif_pkg::INITIAL_INTERVAL_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             beat_valid,
    output logic                             beat_stall,
    input  rrif_pkg::rrif_in_t               beat,
    output logic                             feat_valid,
    input  logic                             feat_stall,
    output rrif_pkg::rrif_out_t              feat,
    input  logic                             cfg_we,
    input  logic [rrif_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rrif_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rrif_pkg::*;

    rrif_cmd_t cmd;
    rrif_sts_t sts;

    // The controller owns sequencing; it only sees the request handshake and
    // the datapath status.
    rrif_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (beat_valid),
        .beat_stall (beat_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // The datapath holds the configuration and interval state, the divider lanes and the output register.
    rrif_datapath #(
        .INITIAL_INTERVAL (INITIAL_INTERVAL)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .beat       (beat),
        .feat_valid (feat_valid),
        .feat_stall (feat_stall),
        .feat       (feat),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

endmodule

/* dv/rrif_feature_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the RR interval feature block: predicts each result from the
// accepted beat requests and compares it with what the block returns.
// Depends on rrif_pkg.
module rrif_feature_checker #(
    parameter int INITIAL_INTERVAL = rrif_pkg::INITIAL_INTERVAL_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             beat_valid,
    input  logic                             beat_stall,
    input  rrif_pkg::rrif_in_t               beat,
    input  logic                             feat_valid,
    input  logic                             feat_stall,
    input  rrif_pkg::rrif_out_t              feat,
    input  logic                             cfg_we,
    input  logic [rrif_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rrif_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               errors,
    output int                               outstanding
);
    import rrif_pkg::*;

    logic [3:0]         decay_shift;
    logic [3:0]         frac_shift;
    logic signed [15:0] hist_prev;
    logic signed [15:0] hist_prev2;
    logic signed [15:0] run_avg;
    rrif_out_t          expected_features[$];
    rrif_out_t          want;

    initial errors = 0;

    // Bit 16 of the return value flags a zero divisor or a clipped quotient.
    function automatic logic [16:0] sat_ratio(input logic signed [15:0] num,
                                              input logic signed [15:0] den,
                                              input logic [3:0] sh);
        longint scaled;
        longint q;
        scaled = longint'(num) * (longint'(1) << sh);
        if (den == 0)
            return {1'b1, ((scaled < 0) ? SAT_NEG : SAT_POS)};
        q = scaled / longint'(den);
        if (q > 32767)
            return {1'b1, SAT_POS};
        if (q < -32768)
            return {1'b1, SAT_NEG};
        return {1'b0, 16'(q)};
    endfunction

    function automatic rrif_out_t predict_features(input rrif_in_t b);
        rrif_out_t   f;
        logic [16:0] r_prev;
        logic [16:0] r_next;
        f.prev_interval    = hist_prev;
        f.next_interval    = 16'(int'(b.this_beat_delay) - int'(b.next_beat_delay));
        f.prev2_interval   = hist_prev2;
        f.average_interval = run_avg;
        f.prev_deviation   = 16'(int'(hist_prev) - int'(run_avg));
        f.next_deviation   = 16'(int'(f.next_interval) - int'(run_avg));
        r_prev = sat_ratio(hist_prev, hist_prev2, frac_shift);
        r_next = sat_ratio(f.next_interval, hist_prev, frac_shift);
        f.ratio_prev      = r_prev[15:0];
        f.ratio_next      = r_next[15:0];
        f.ratio_saturated = r_prev[16] | r_next[16];
        return f;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            decay_shift = DECAY_SHIFT_RESET;
            frac_shift  = RATIO_SHIFT_RESET;
            hist_prev   = 16'(INITIAL_INTERVAL);
            hist_prev2  = 16'(INITIAL_INTERVAL);
            run_avg     = 16'(INITIAL_INTERVAL);
            expected_features.delete();
            outstanding <= 0;
        end else begin
            if (feat_valid && !feat_stall) begin
                if (expected_features.size() == 0) begin
                    $error("result returned with no request outstanding");
                    errors++;
                end else begin
                    want = expected_features.pop_front();
                    check_field("prev_interval", want.prev_interval, feat.prev_interval);
                    check_field("next_interval", want.next_interval, feat.next_interval);
                    check_field("prev2_interval", want.prev2_interval, feat.prev2_interval);
                    check_field("average_interval", want.average_interval,
                                feat.average_interval);
                    check_field("prev_deviation", want.prev_deviation, feat.prev_deviation);
                    check_field("next_deviation", want.next_deviation, feat.next_deviation);
                    check_field("ratio_prev", want.ratio_prev, feat.ratio_prev);
                    check_field("ratio_next", want.ratio_next, feat.ratio_next);
                    check_field("ratio_saturated", want.ratio_saturated,
                                feat.ratio_saturated);
                end
            end
            if (beat_valid && !beat_stall) begin
                want = predict_features(beat);
                expected_features.push_back(want);
                run_avg = 16'(int'(run_avg) - int'(run_avg >>> decay_shift)
                              + int'(want.next_interval >>> decay_shift));
                hist_prev2 = hist_prev;
                hist_prev  = want.next_interval;
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_AVERAGE_DECAY_SHIFT: decay_shift = cfg_data;
                    REG_RATIO_SHIFT:         frac_shift  = cfg_data;
                    default: ;
                endcase
            end
            outstanding <= expected_features.size();
        end
    end

endmodule

/* dv/tb_rr_interval_features.sv */
`timescale 1ns / 1ps
// Testbench top for rr_interval_features: clock, reset, beat requests, random
// stalls, register writes and the verdict. Depends on rrif_pkg, the block and
// rrif_feature_checker, which does all prediction and comparison.
module tb_rr_interval_features;
    import rrif_pkg::*;

    localparam int INIT_IV        = INITIAL_INTERVAL_DEF;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 100;
    // Idle gaps and stalls stretch the time that a request takes, yet this many
    // cycles without any handshake can only mean a hang.
    localparam int WATCHDOG_LIMIT = 2000;
    // Pause before register writes, after the last result of a phase.
    localparam int IDLE_PAUSE     = 4;
    // Cycles to wait after the last result so that a stray one would show up.
    localparam int END_PAUSE      = 40;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   beat_valid  = 1'b0;
    logic                   beat_stall;
    rrif_in_t               beat        = '0;
    logic                   feat_valid;
    logic                   feat_stall  = 1'b0;
    rrif_out_t              feat;
    logic                   cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;

    int mismatches;
    int features_due;
    int beat_idle_pct  = 0;
    int feat_stall_pct = 0;
    int quiet_cycles   = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    rr_interval_features #(
        .INITIAL_INTERVAL(INIT_IV)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (beat_valid),
        .beat_stall (beat_stall),
        .beat       (beat),
        .feat_valid (feat_valid),
        .feat_stall (feat_stall),
        .feat       (feat),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    rrif_feature_checker #(
        .INITIAL_INTERVAL(INIT_IV)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .beat_valid  (beat_valid),
        .beat_stall  (beat_stall),
        .beat        (beat),
        .feat_valid  (feat_valid),
        .feat_stall  (feat_stall),
        .feat        (feat),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (mismatches),
        .outstanding (features_due)
    );

    // The result side stalls at random, independent of feat_valid.
    always @(posedge clk) begin
        feat_stall <= ($urandom_range(99, 0) < feat_stall_pct);
    end

    // Watchdog: counts cycles in which neither channel completes a handshake.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((beat_valid && !beat_stall) || (feat_valid && !feat_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    // Presents one beat request and returns at the edge where it is taken.
    // Random idle cycles go in front of it; valid stays high from one request
    // to the next when no idle cycle is drawn, so back-to-back requests work.
    task automatic send_beat(input int this_d, input int next_d);
        while ($urandom_range(99, 0) < beat_idle_pct) begin
            beat_valid <= 1'b0;
            @(posedge clk);
        end
        beat_valid <= 1'b1;
        // The concatenation follows the struct order: this delay, next delay.
        beat       <= {15'(this_d), 15'(next_d)};
        do
            @(posedge clk);
        while (beat_stall);
    endtask

    // Mostly realistic heart rhythms with random phase, some intervals close
    // to zero to hit the zero divisor and overflow cases, and some noise with
    // fully random delays, which also gives negative intervals.
    task automatic send_random_beat();
        int sel;
        int iv;
        int this_d;
        int next_d;
        sel = $urandom_range(99, 0);
        if (sel < 70) begin
            iv     = $urandom_range(600, 100);
            this_d = $urandom_range(32767, iv);
            next_d = this_d - iv;
        end else if (sel < 82) begin
            iv     = int'($urandom_range(8, 0)) - 4;
            this_d = $urandom_range(32763, 4);
            next_d = this_d - iv;
        end else begin
            this_d = $urandom_range(32767, 0);
            next_d = $urandom_range(32767, 0);
        end
        send_beat(this_d, next_d);
    endtask

    // Stops sending and waits until every result has come back, so that the
    // block is idle for the register writes that follow. The first edge lets
    // the outstanding count take in the request accepted last.
    task automatic drain_features();
        beat_valid <= 1'b0;
        @(posedge clk);
        while (features_due != 0)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    // Writes both registers, then the two unused indexes with random data,
    // which the block must ignore. cfg_we stays high across the writes.
    task automatic configure(input logic [3:0] decay, input logic [3:0] rshift);
        for (int idx = 0; idx < (1 << CFG_INDEX_W); idx++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_INDEX_W'(idx);
            if (CFG_INDEX_W'(idx) == REG_AVERAGE_DECAY_SHIFT)
                cfg_data <= decay;
            else if (CFG_INDEX_W'(idx) == REG_RATIO_SHIFT)
                cfg_data <= rshift;
            else
                cfg_data <= CFG_DATA_W'($urandom_range(15, 0));
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    initial begin
        int pct;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests under the reset register values. The history
        // starts at the initial interval; zero intervals then make zero
        // divisors with zero, positive and negative numerators.
        send_beat(0, 0);
        send_beat(0, 0);
        send_beat(0, 500);
        send_beat(32767, 0);
        send_beat(0, 32767);
        send_beat(32767, 32767);
        send_beat(1, 0);
        // A large interval over an interval of one overflows the ratio.
        send_beat(300, 0);
        send_beat(0, 1);
        send_beat(1000, 760);
        send_beat(2000, 1750);
        send_beat(5000, 4755);
        drain_features();

        // No fraction bits and no averaging decay.
        configure(4'd0, 4'd0);
        send_beat(4000, 3750);
        send_beat(4300, 4040);
        send_beat(0, 0);
        send_beat(32767, 0);
        drain_features();

        // Both shifts at their top; a ratio shift of 15 saturates nearly
        // everything, which the block must still flag.
        configure(4'd15, 4'd15);
        send_beat(9000, 8700);
        send_beat(9000, 8700);
        send_beat(0, 32767);
        send_beat(32767, 0);
        send_beat(100, 99);
        drain_features();

        // Random part: each phase has its own register setting, the first
        // ones at the extremes, and two phases run without any idling.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       configure(4'd0, 4'd0);
                1:       configure(4'd15, 4'd15);
                2:       configure(4'd15, 4'd0);
                3:       configure(4'd0, 4'd14);
                default: configure(4'($urandom_range(15, 0)), 4'($urandom_range(15, 0)));
            endcase
            pct = (p == 4 || p == 5) ? 0 : 33;
            beat_idle_pct  <= pct;
            feat_stall_pct <= pct;
            repeat (PHASE_ITEMS) send_random_beat();
            drain_features();
        end

        repeat (END_PAUSE) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
